>>> hw/rtl/sccal_pkg.sv
package sccal_pkg;

  // field and fixed-point widths
  localparam int SCALE_W     = 24;
  localparam int HOUR_W      = 37;
  localparam int HOUR_FRAC   = 32;
  localparam int DAY_OUT_W   = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_OUT_W  = 16;
  localparam int TOTAL_W     = 41;
  localparam int FRAC_W      = 16;
  localparam int TD_W        = TOTAL_W - FRAC_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(5120);

  // 3600000 = 2^7 * 28125, so inc = floor(prod * 2^17 / 28125)
  localparam int INC_SHIFT   = 17;
  localparam int INC_DIVISOR = 28125;
  // one day = 24 * 2^32 = 3 * 2^35 hour units
  localparam int DAY_SHIFT   = 35;
  localparam int HREM_W      = HOUR_W - DAY_SHIFT;
  // hour / (24 * 2^16) = (hour >> 19) / 3
  localparam int FRAC_SHIFT  = 19;
  localparam int FRAC_NUM_W  = HOUR_W - FRAC_SHIFT;
  localparam int DIV_BY_3    = 3;

  localparam int DAYS_PER_YEAR = 365;
  localparam int MONTHS        = 12;

  localparam logic [HOUR_W-1:0] DAY_UNITS = HOUR_W'(64'd24 << HOUR_FRAC);

  // divider: quotient bits retired per cycle, divisor width
  localparam int RADIX  = 4;
  localparam int DVSR_W = 15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_INC,
    ST_INC_WAIT,
    ST_DAY,
    ST_DAY_WAIT,
    ST_YEAR_CHK,
    ST_YEAR,
    ST_YEAR_WAIT,
    ST_MONTH,
    ST_FRAC,
    ST_FRAC_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_INC,
    DIV_DAY,
    DIV_YEAR,
    DIV_FRAC
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     take_inc;
    logic     take_day;
    logic     take_year;
    logic     month_step;
    logic     take_frac;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic day_gt_year;
    logic month_more;
    logic out_free;
  } dp_stat_t;

  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                         len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

  // days of the months before month m
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/sccal_div.sv
module sccal_div #(
  parameter int DIV_W = 60,
  localparam int CNT_W = $clog2(DIV_W / sccal_pkg::RADIX + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIV_W-1:0]              numer_i,
  input  logic [sccal_pkg::DVSR_W-1:0]  dvsr_i,
  input  logic [CNT_W-1:0]              steps_i,
  output logic                          busy_o,
  output logic [DIV_W-1:0]              quot_o,
  output logic [sccal_pkg::DVSR_W-1:0]  rem_o
);
  import sccal_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVSR_W-1:0] rem_q, rem_d;
  logic [DVSR_W-1:0] dvsr_q;
  logic [DVSR_W:0]   trial;

  // restoring long division, RADIX quotient bits per cycle
  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < RADIX; i++) begin
      trial = {rem_d, num_d[DIV_W-1]};
      num_d = num_d << 1;
      if (trial >= {1'b0, dvsr_q}) begin
        rem_d = DVSR_W'(trial - {1'b0, dvsr_q});
        quo_d = {quo_d[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVSR_W-1:0];
        quo_d = {quo_d[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= numer_i;
      rem_q  <= '0;
      quo_q  <= '0;
      dvsr_q <= dvsr_i;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/sccal_dp.sv
module sccal_dp #(
  parameter int DELTA_BITS = 16,
  parameter int YEAR_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sccal_pkg::dp_cmd_t                cmd_i,
  output sccal_pkg::dp_stat_t               stat_o,
  input  logic [DELTA_BITS-1:0]             delta_ms_i,
  input  logic                              cfg_we_i,
  input  logic [sccal_pkg::SCALE_W-1:0]     cfg_wdata_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [sccal_pkg::HOUR_W-1:0]      hour_of_day_o,
  output logic [sccal_pkg::DAY_OUT_W-1:0]   day_count_o,
  output logic [sccal_pkg::MONTH_W-1:0]     month_index_o,
  output logic [sccal_pkg::YEAR_OUT_W-1:0]  year_count_o,
  output logic [sccal_pkg::TOTAL_W-1:0]     total_days_o
);
  import sccal_pkg::*;

  localparam int PROD_W = DELTA_BITS + SCALE_W;
  localparam int Q_W    = PROD_W + 3;
  localparam int SUM_W  = ((Q_W > HOUR_W) ? Q_W : HOUR_W) + 1;
  localparam int HI_W   = SUM_W - DAY_SHIFT;
  localparam int DAY_W  = ((HI_W > 9) ? HI_W : 9) + 1;
  localparam int YM_W   = YEAR_BITS + 9;
  // dividend widths rounded up to whole divider cycles
  localparam int W_INC  = ((PROD_W + INC_SHIFT + RADIX - 1) / RADIX) * RADIX;
  localparam int W_DAY  = ((HI_W + RADIX - 1) / RADIX) * RADIX;
  localparam int W_YEAR = ((DAY_W + RADIX - 1) / RADIX) * RADIX;
  localparam int W_FRAC = ((FRAC_NUM_W + RADIX - 1) / RADIX) * RADIX;
  localparam int DIV_W  = W_INC;
  localparam int CNT_W  = $clog2(DIV_W / RADIX + 1);

  logic [SCALE_W-1:0]    scale_q;
  logic [DELTA_BITS-1:0] delta_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SUM_W-1:0]      sum_q;
  logic [HOUR_W-1:0]     hour_q;
  logic [DAY_W-1:0]      day_q;
  logic [MONTH_W-1:0]    month_q;
  logic [YEAR_BITS-1:0]  year_q;
  logic [FRAC_W-1:0]     frac_q;
  logic [TD_W-1:0]       base_q;
  logic [YM_W-1:0]       year_days;
  logic [DAY_W-1:0]      cur_len;
  logic                  out_valid_q, out_valid_d, out_free;

  logic [HOUR_W-1:0]     hour_out_q;
  logic [DAY_OUT_W-1:0]  day_out_q;
  logic [MONTH_W-1:0]    month_out_q;
  logic [YEAR_OUT_W-1:0] year_out_q;
  logic [TOTAL_W-1:0]    total_out_q;

  logic [DIV_W-1:0]      div_numer;
  logic [DVSR_W-1:0]     div_dvsr;
  logic [CNT_W-1:0]      div_steps;
  logic                  div_busy;
  logic [DIV_W-1:0]      div_quot;
  logic [DVSR_W-1:0]     div_rem;

  // operand select for the shared divider
  always_comb begin
    div_numer = '0;
    div_dvsr  = DVSR_W'(INC_DIVISOR);
    div_steps = CNT_W'(W_INC / RADIX);
    case (cmd_i.div_sel)
      DIV_INC: begin
        div_numer = DIV_W'({prod_q, {INC_SHIFT{1'b0}}}) << (DIV_W - W_INC);
        div_dvsr  = DVSR_W'(INC_DIVISOR);
        div_steps = CNT_W'(W_INC / RADIX);
      end
      DIV_DAY: begin
        div_numer = DIV_W'(sum_q[SUM_W-1:DAY_SHIFT]) << (DIV_W - W_DAY);
        div_dvsr  = DVSR_W'(DIV_BY_3);
        div_steps = CNT_W'(W_DAY / RADIX);
      end
      DIV_YEAR: begin
        div_numer = DIV_W'(day_q - DAY_W'(1)) << (DIV_W - W_YEAR);
        div_dvsr  = DVSR_W'(DAYS_PER_YEAR);
        div_steps = CNT_W'(W_YEAR / RADIX);
      end
      DIV_FRAC: begin
        div_numer = DIV_W'(hour_q[HOUR_W-1:FRAC_SHIFT]) << (DIV_W - W_FRAC);
        div_dvsr  = DVSR_W'(DIV_BY_3);
        div_steps = CNT_W'(W_FRAC / RADIX);
      end
    endcase
  end

  sccal_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (div_numer),
    .dvsr_i  (div_dvsr),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign cur_len     = DAY_W'(month_len(month_q));
  assign year_days   = YM_W'(year_q) * YM_W'(DAYS_PER_YEAR);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  assign stat_o.div_busy    = div_busy;
  assign stat_o.day_gt_year = (day_q > DAY_W'(DAYS_PER_YEAR));
  assign stat_o.month_more  = (day_q > cur_len);
  assign stat_o.out_free    = out_free;

  // calendar state and the time scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= SCALE_RESET;
      hour_q      <= '0;
      day_q       <= '0;
      month_q     <= '0;
      year_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.take_day) begin
        hour_q <= {HREM_W'(div_rem), sum_q[DAY_SHIFT-1:0]};
        day_q  <= day_q + DAY_W'(div_quot);
      end else if (cmd_i.take_year) begin
        day_q  <= DAY_W'(div_rem) + DAY_W'(1);
        year_q <= year_q + YEAR_BITS'(div_quot);
      end else if (cmd_i.month_step) begin
        day_q <= day_q - cur_len;
        if (month_q == MONTH_W'(MONTHS - 1)) begin
          month_q <= '0;
          year_q  <= year_q + YEAR_BITS'(1);
        end else begin
          month_q <= month_q + MONTH_W'(1);
        end
      end
    end
  end

  // working registers and the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      delta_q <= delta_ms_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(delta_q) * PROD_W'(scale_q);
    end
    if (cmd_i.take_inc) begin
      sum_q <= SUM_W'(hour_q) + SUM_W'(div_quot);
    end
    if (cmd_i.take_frac) begin
      frac_q <= FRAC_W'(div_quot);
      base_q <= TD_W'(year_days);
    end
    if (cmd_i.out_load) begin
      hour_out_q  <= hour_q;
      day_out_q   <= DAY_OUT_W'(day_q);
      month_out_q <= month_q;
      year_out_q  <= YEAR_OUT_W'(year_q);
      total_out_q <= {base_q + TD_W'(month_start(month_q)) + TD_W'(day_q), frac_q};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hour_of_day_o = hour_out_q;
  assign day_count_o   = day_out_q;
  assign month_index_o = month_out_q;
  assign year_count_o  = year_out_q;
  assign total_days_o  = total_out_q;

`ifndef SYNTHESIS
  a_hour_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hour_q < DAY_UNITS)
    else $error("hour accumulator reached a full day");

  a_calendar_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (day_q <= DAY_W'(31)) && (month_q < MONTH_W'(MONTHS)))
    else $error("calendar not normalized when result is loaded");
`endif

endmodule

>>> hw/rtl/sccal_ctrl.sv
module sccal_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output sccal_pkg::dp_cmd_t   cmd_o,
  input  sccal_pkg::dp_stat_t  stat_i
);
  import sccal_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MUL;
      ST_MUL:       state_d = ST_INC;
      ST_INC:       state_d = ST_INC_WAIT;
      ST_INC_WAIT:  if (!stat_i.div_busy) state_d = ST_DAY;
      ST_DAY:       state_d = ST_DAY_WAIT;
      ST_DAY_WAIT:  if (!stat_i.div_busy) state_d = ST_YEAR_CHK;
      ST_YEAR_CHK: begin
        state_d = stat_i.day_gt_year ? ST_YEAR : ST_MONTH;
      end
      ST_YEAR:      state_d = ST_YEAR_WAIT;
      ST_YEAR_WAIT: if (!stat_i.div_busy) state_d = ST_MONTH;
      ST_MONTH:     if (!stat_i.month_more) state_d = ST_FRAC;
      ST_FRAC:      state_d = ST_FRAC_WAIT;
      ST_FRAC_WAIT: if (!stat_i.div_busy) state_d = ST_OUT;
      ST_OUT:       if (stat_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_INC;
    unique case (state_q)
      ST_IDLE:      cmd_o.load_in = in_valid_i;
      ST_MUL:       cmd_o.mul = 1'b1;
      ST_INC: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_INC;
      end
      ST_INC_WAIT:  cmd_o.take_inc = !stat_i.div_busy;
      ST_DAY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DAY;
      end
      ST_DAY_WAIT:  cmd_o.take_day = !stat_i.div_busy;
      ST_YEAR_CHK:  cmd_o.div_sel = DIV_INC;
      ST_YEAR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_YEAR;
      end
      ST_YEAR_WAIT: cmd_o.take_year = !stat_i.div_busy;
      ST_MONTH:     cmd_o.month_step = stat_i.month_more;
      ST_FRAC: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_FRAC;
      end
      ST_FRAC_WAIT: cmd_o.take_frac = !stat_i.div_busy;
      ST_OUT:       cmd_o.out_load = stat_i.out_free;
      default:      cmd_o.div_sel = DIV_INC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.div_busy)
    else $error("divider restarted while busy");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result overwrote a pending output");

  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL))
    else $error("accepted transfer did not start the multiply");
`endif

endmodule

>>> hw/rtl/scaled_calendar_clock.sv
// scaled calendar clock: game time of day and a 365-day calendar
// input channel: in_valid_i / in_stall_o with delta_ms_i, the real
//   milliseconds since the previous transfer
// output channel: out_valid_o / out_stall_i with hour of day (UQ5.32),
//   day, month, year and total days (units of 1/65536 day)
// time_scale is written through cfg_we_i / cfg_wdata_i; the user must write
//   it only while the block idles, which the block itself does not enforce
// one item at a time: a multiply, then a shared radix-16 constant divider
//   scales the interval, splits off days, drops whole years and forms the
//   day fraction; months roll one per cycle
// at most two months roll over per transfer, since one transfer adds at most
//   about fifty days; whole years are dropped only with a wider DELTA_BITS;
//   the next input is taken the cycle after the result is loaded
// a result waiting on out_stall_i does not block the next input; only a
//   second finished result waits in the final state until the first leaves
// reset clears the calendar to zero, sets the scale to 20.0 and drops any
//   pending result
module scaled_calendar_clock #(
  parameter int DELTA_BITS = 16,
  parameter int YEAR_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [DELTA_BITS-1:0]             delta_ms_i,
  // configuration write
  input  logic                              cfg_we_i,
  input  logic [sccal_pkg::SCALE_W-1:0]     cfg_wdata_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sccal_pkg::HOUR_W-1:0]      hour_of_day_o,
  output logic [sccal_pkg::DAY_OUT_W-1:0]   day_count_o,
  output logic [sccal_pkg::MONTH_W-1:0]     month_index_o,
  output logic [sccal_pkg::YEAR_OUT_W-1:0]  year_count_o,
  output logic [sccal_pkg::TOTAL_W-1:0]     total_days_o
);
  import sccal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks one item through multiply, divides and month rolls
  sccal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // datapath: calendar state, scale register, divider and output register
  sccal_dp #(
    .DELTA_BITS (DELTA_BITS),
    .YEAR_BITS  (YEAR_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .delta_ms_i    (delta_ms_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .hour_of_day_o (hour_of_day_o),
    .day_count_o   (day_count_o),
    .month_index_o (month_index_o),
    .year_count_o  (year_count_o),
    .total_days_o  (total_days_o)
  );

endmodule
